[src/mp2d_pkg.sv]
package mp2d_pkg;

  // configuration register widths and port shape
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_POOL_W = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // default build sizes
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_POOL   = 8;
  localparam int DEF_PIXEL_BITS = 16;

  // register reset values
  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH  = 9'd28;
  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT = 9'd28;
  localparam logic [CFG_POOL_W-1:0] RST_POOL_HEIGHT  = 4'd2;
  localparam logic [CFG_POOL_W-1:0] RST_POOL_WIDTH   = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_POOL_HEIGHT  = 2'd2,
    REG_POOL_WIDTH   = 2'd3
  } mp2d_reg_t;

  // line store access request for one cycle
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mp2d_ls_ctrl_t;

  // what the second stage does with a word
  typedef struct packed {
    logic emit;
    logic write;
    logic use_partial;
    logic end_of_row;
    logic end_of_image;
  } mp2d_s1_ctrl_t;

endpackage

[src/max_pooling_2d_core.sv]
// streaming 2-d max pooling
// input channel: one pixel word per accepted transfer (in_valid high, in_stall
// low), pixels of the image in raster order
// output channel: one word per pool window in raster order of the windows,
// carrying the window maximum, an end_of_row flag on the last window of a
// pooled row and an end_of_image flag on the last window of the image
// configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 image width, 1 image height, 2 pool height, 3 pool width); write only
// while the block is idle; zero sizes act as 1, oversized ones as the maximum
// throughput: one pixel per cycle while in_stall is low; every pixel closing
// a window column reads the line store on acceptance, and the next stage
// writes the combined maximum back unless the window is complete, with
// forwarding for back-to-back hits; a window's result is registered in the
// second stage and then in the output register, which drives out_valid
// stall: a stalled result sits in the output register; pixels are still taken
// until the next finished window waits behind it in the second stage, then
// in_stall rises until the output drains
// reset: counters clear and registers take their defaults; the line store
// needs no clearing pass since a stored entry is used only after it is written
module max_pooling_2d_core #(
  parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_POOL   = mp2d_pkg::DEF_MAX_POOL,
  parameter int PIXEL_BITS = mp2d_pkg::DEF_PIXEL_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [PIXEL_BITS-1:0]     in_pixel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [PIXEL_BITS-1:0]     out_pooled_max,
  output logic                             out_end_of_row,
  output logic                             out_end_of_image
);
  import mp2d_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int OFF_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int SZ_W  = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
  localparam int PSZ_W = ($clog2(MAX_POOL + 1) > CFG_POOL_W) ?
                         $clog2(MAX_POOL + 1) : CFG_POOL_W;
  localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  // configuration registers
  logic [CFG_DIM_W-1:0]  img_w_r, img_h_r;
  logic [CFG_POOL_W-1:0] pool_h_r, pool_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= RST_IMAGE_WIDTH;
      img_h_r  <= RST_IMAGE_HEIGHT;
      pool_h_r <= RST_POOL_HEIGHT;
      pool_w_r <= RST_POOL_WIDTH;
    end else if (cfg_wr_en) begin
      unique case (mp2d_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  img_w_r  <= cfg_data[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_r  <= cfg_data[CFG_DIM_W-1:0];
        REG_POOL_HEIGHT:  pool_h_r <= cfg_data[CFG_POOL_W-1:0];
        REG_POOL_WIDTH:   pool_w_r <= cfg_data[CFG_POOL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [SZ_W-1:0]  w_eff, h_eff;
  logic [PSZ_W-1:0] pw_eff, ph_eff;

  always_comb begin
    w_eff  = SZ_W'(img_w_r);
    h_eff  = SZ_W'(img_h_r);
    pw_eff = PSZ_W'(pool_w_r);
    ph_eff = PSZ_W'(pool_h_r);
    if (img_w_r == '0) w_eff = SZ_W'(1);
    else if (SZ_W'(img_w_r) > SZ_W'(MAX_WIDTH)) w_eff = SZ_W'(MAX_WIDTH);
    if (img_h_r == '0) h_eff = SZ_W'(1);
    else if (SZ_W'(img_h_r) > SZ_W'(MAX_WIDTH)) h_eff = SZ_W'(MAX_WIDTH);
    if (pool_w_r == '0) pw_eff = PSZ_W'(1);
    else if (PSZ_W'(pool_w_r) > PSZ_W'(MAX_POOL)) pw_eff = PSZ_W'(MAX_POOL);
    if (pool_h_r == '0) ph_eff = PSZ_W'(1);
    else if (PSZ_W'(pool_h_r) > PSZ_W'(MAX_POOL)) ph_eff = PSZ_W'(MAX_POOL);
  end

  // position state
  logic [COL_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [OFF_W-1:0] off_c_r, off_c_nxt, off_r_r, off_r_nxt;
  logic signed [PIXEL_BITS-1:0] run_max_r, run_max_nxt, rm_new;

  // second stage
  logic                         s1_v_r, s1_v_nxt;
  mp2d_s1_ctrl_t                s1_ctrl_r, s1_ctrl_nxt;
  logic signed [PIXEL_BITS-1:0] s1_rm_r;
  logic [COL_W-1:0]             s1_idx_r, idx;
  logic                         s1_fire;
  logic signed [PIXEL_BITS-1:0] part, combined;

  // output register
  logic                         out_v_r, out_v_nxt;
  logic signed [PIXEL_BITS-1:0] out_max_r;
  logic                         out_eor_r, out_eoi_r;

  logic in_acc;
  logic col_end, row_end, wce, wre;
  mp2d_ls_ctrl_t ls_ctrl;

  assign s1_fire  = s1_v_r && (!s1_ctrl_r.emit || !out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    rm_new  = ((off_c_r == '0) || (in_pixel_value > run_max_r)) ? in_pixel_value
                                                                 : run_max_r;
    col_end = (SZ_W'(col_r) + SZ_W'(1)) >= w_eff;
    row_end = (SZ_W'(row_r) + SZ_W'(1)) >= h_eff;
    wce     = col_end || ((PSZ_W'(off_c_r) + PSZ_W'(1)) >= pw_eff);
    wre     = row_end || ((PSZ_W'(off_r_r) + PSZ_W'(1)) >= ph_eff);
    // first column of the current window
    idx = (SZ_W'(off_c_r) <= SZ_W'(col_r)) ? COL_W'(SZ_W'(col_r) - SZ_W'(off_c_r))
                                           : '0;

    run_max_nxt = wce ? PIX_MIN : rm_new;
    off_c_nxt   = wce ? '0 : off_c_r + OFF_W'(1);
    col_nxt     = col_r + COL_W'(1);
    row_nxt     = row_r;
    off_r_nxt   = off_r_r;
    if (col_end) begin
      col_nxt   = '0;
      off_c_nxt = '0;
      if (row_end) begin
        row_nxt   = '0;
        off_r_nxt = '0;
      end else begin
        row_nxt   = row_r + COL_W'(1);
        off_r_nxt = wre ? '0 : off_r_r + OFF_W'(1);
      end
    end

    s1_ctrl_nxt.emit         = wce && wre;
    s1_ctrl_nxt.write        = wce && !wre;
    s1_ctrl_nxt.use_partial  = off_r_r != '0;
    s1_ctrl_nxt.end_of_row   = col_end;
    s1_ctrl_nxt.end_of_image = col_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      off_c_r   <= '0;
      off_r_r   <= '0;
      run_max_r <= PIX_MIN;
    end else if (in_acc) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      off_c_r   <= off_c_nxt;
      off_r_r   <= off_r_nxt;
      run_max_r <= run_max_nxt;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) s1_v_nxt = 1'b1;
    else if (s1_fire) s1_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r <= s1_ctrl_nxt;
      s1_rm_r   <= rm_new;
      s1_idx_r  <= idx;
    end
  end

  assign ls_ctrl.rd_en = in_acc && wce;
  assign ls_ctrl.wr_en = s1_fire && s1_ctrl_r.write;

  mp2d_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ls_ctrl),
    .rd_addr (idx),
    .wr_addr (s1_idx_r),
    .wr_data (combined),
    .rd_data (part)
  );

  assign combined = (s1_ctrl_r.use_partial && (part > s1_rm_r)) ? part : s1_rm_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire && s1_ctrl_r.emit) out_v_nxt = 1'b1;
    else if (out_v_r && !out_stall) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctrl_r.emit) begin
      out_max_r <= combined;
      out_eor_r <= s1_ctrl_r.end_of_row;
      out_eoi_r <= s1_ctrl_r.end_of_image;
    end
  end

  assign out_valid        = out_v_r;
  assign out_pooled_max   = out_max_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_image = out_eoi_r;

`ifndef SYNTHESIS
  a_stall_needs_busy_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s1_ctrl_r.emit && out_v_r))
    else $error("input stalled without a blocked result");

  a_emit_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !(s1_ctrl_r.emit && s1_ctrl_r.write))
    else $error("word both emitted and written back");

  a_held_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_fire) |=> (s1_v_r && $stable(s1_idx_r) && $stable(s1_rm_r)))
    else $error("held stage lost its word");

  a_eoi_implies_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_eoi_r || out_eor_r))
    else $error("end of image without end of row");

  a_no_write_without_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ls_ctrl.wr_en |-> (s1_v_r && !s1_ctrl_r.emit))
    else $error("line store write outside a write-back");
`endif

endmodule

[src/mp2d_line_store.sv]
module mp2d_line_store #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mp2d_pkg::mp2d_ls_ctrl_t  ctrl,
  input  logic [ADDR_W-1:0]        rd_addr,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  output logic signed [DATA_W-1:0] rd_data
);
  import mp2d_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_q_r;
  logic signed [DATA_W-1:0] fwd_data_r;
  logic                     fwd_r;
  logic                     fwd_nxt;

  // a write landing on the entry being read in the same cycle wins
  assign fwd_nxt = ctrl.rd_en && ctrl.wr_en && (rd_addr == wr_addr);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ctrl.rd_en) begin
      fwd_r <= fwd_nxt;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

[dv/tb_max_pooling_2d_core.sv]
module tb_max_pooling_2d_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mp2d_pkg::*;

  localparam int PIX_W = DEF_PIXEL_BITS;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;

  typedef struct {
    logic signed [PIX_W-1:0] pooled_max;
    logic                    end_of_row;
    logic                    end_of_image;
  } pooled_word_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [PIX_W-1:0] in_pixel_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [PIX_W-1:0] out_pooled_max;
  logic                    out_end_of_row;
  logic                    out_end_of_image;

  max_pooling_2d_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pooled_max   (out_pooled_max),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_image (out_end_of_image)
  );

  // pooling model state
  logic [CFG_DIM_W-1:0]    reg_image_width;
  logic [CFG_DIM_W-1:0]    reg_image_height;
  logic [CFG_POOL_W-1:0]   reg_pool_height;
  logic [CFG_POOL_W-1:0]   reg_pool_width;
  int unsigned             col_pos;
  int unsigned             row_pos;
  int unsigned             win_col;
  int unsigned             win_row;
  logic signed [PIX_W-1:0] run_max;
  logic signed [PIX_W-1:0] column_max_store [DEF_MAX_WIDTH];

  pooled_word_t pending_windows [$];
  int unsigned  errors;
  int unsigned  pixels_sent;
  int unsigned  hold_off_cycles;
  int unsigned  stall_left;
  bit           sender_gapless;
  bit           receiver_calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // advance the pooling model by one accepted pixel word
  function automatic void pool_pixel(input logic signed [PIX_W-1:0] px);
    int unsigned             w;
    int unsigned             h;
    int unsigned             ph;
    int unsigned             pw;
    int unsigned             slot;
    bit                      last_col;
    bit                      last_row;
    bit                      win_col_done;
    bit                      win_row_done;
    logic signed [PIX_W-1:0] best;
    pooled_word_t            word;
    w  = clamp_dim(reg_image_width, DEF_MAX_WIDTH);
    h  = clamp_dim(reg_image_height, DEF_MAX_WIDTH);
    ph = clamp_dim(reg_pool_height, DEF_MAX_POOL);
    pw = clamp_dim(reg_pool_width, DEF_MAX_POOL);
    if (win_col == 0 || px > run_max) run_max = px;
    last_col     = (col_pos + 1 >= w);
    last_row     = (row_pos + 1 >= h);
    win_col_done = last_col || (win_col + 1 >= pw);
    win_row_done = last_row || (win_row + 1 >= ph);
    if (win_col_done) begin
      slot = (win_col <= col_pos) ? col_pos - win_col : 0;
      if (slot >= DEF_MAX_WIDTH) slot = DEF_MAX_WIDTH - 1;
      best = run_max;
      if (win_row != 0 && column_max_store[slot] > best) best = column_max_store[slot];
      if (win_row_done) begin
        word.pooled_max   = best;
        word.end_of_row   = last_col;
        word.end_of_image = last_col && last_row;
        pending_windows = {pending_windows, word};
      end else begin
        column_max_store[slot] = best;
      end
      win_col = 0;
      run_max = PIX_MIN;
    end else begin
      win_col++;
    end
    if (last_col) begin
      col_pos = 0;
      win_col = 0;
      if (last_row) begin
        row_pos = 0;
        win_row = 0;
      end else begin
        row_pos++;
        win_row = win_row_done ? 0 : win_row + 1;
      end
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic signed [PIX_W-1:0] random_pixel();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return PIX_MIN;
      1: return PIX_MAX;
      2: return PIX_W'($signed($urandom_range(0, 16)) - 8);
      default: return r[PIX_W-1:0];
    endcase
  endfunction

  function automatic void check_pooled_word();
    pooled_word_t want;
    if (pending_windows.size() == 0) begin
      $display("%0t: unexpected word, pooled_max expected none got %0d", $time, out_pooled_max);
      errors++;
      return;
    end
    want = pending_windows.pop_front();
    if (out_pooled_max !== want.pooled_max) begin
      $display("%0t: pooled_max expected %0d got %0d", $time, want.pooled_max, out_pooled_max);
      errors++;
    end
    if (out_end_of_row !== want.end_of_row) begin
      $display("%0t: end_of_row expected %0b got %0b", $time, want.end_of_row, out_end_of_row);
      errors++;
    end
    if (out_end_of_image !== want.end_of_image) begin
      $display("%0t: end_of_image expected %0b got %0b", $time, want.end_of_image,
               out_end_of_image);
      errors++;
    end
  endfunction

  // receiving side: random stall per word, plus long hold-offs on request
  initial begin
    bit stall_next;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_pooled_word();
        stall_left = receiver_calm ? 0 : $urandom_range(0, 9);
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // valid stays high after acceptance so back-to-back words need no extra edge
  task automatic send_pixel(input logic signed [PIX_W-1:0] px);
    int unsigned gap;
    gap = sender_gapless ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_until_image_end();
    do begin
      send_pixel(random_pixel());
    end while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    // a pixel that closes no window may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input mp2d_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  reg_image_width  = value[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT: reg_image_height = value[CFG_DIM_W-1:0];
      REG_POOL_HEIGHT:  reg_pool_height  = value[CFG_POOL_W-1:0];
      REG_POOL_WIDTH:   reg_pool_width   = value[CFG_POOL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] ph,
                              input logic [CFG_DATA_W-1:0] pw);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_POOL_HEIGHT, ph);
    write_reg(REG_POOL_WIDTH, pw);
  endtask

  // two rows at the reset sizes, then the height drops below the current row
  task automatic test_reset_defaults();
    repeat (56) send_pixel(random_pixel());
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 9'd2);
    send_until_image_end();
  endtask

  task automatic test_corner_pixels();
    // single pixel images
    set_geometry(9'd1, 9'd1, 9'd1, 9'd1);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MAX);
    // zero sizes act as one
    set_geometry(9'd0, 9'd0, 9'd0, 9'd0);
    send_pixel(16'sh5555);
    send_pixel(-16'sh5556);
    // right and bottom windows cut short, stored column max wins on the right
    set_geometry(9'd3, 9'd3, 9'd2, 9'd2);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MIN);
    send_pixel(-16'sd1);
    send_pixel(16'sd0);
    send_pixel(16'sd1);
    send_pixel(PIX_MIN);
    // current row beats the stored column max
    set_geometry(9'd2, 9'd2, 9'd2, 9'd2);
    send_pixel(-16'sd7);
    send_pixel(16'sd3);
    send_pixel(16'sd100);
    send_pixel(-16'sd100);
  endtask

  task automatic test_register_extremes();
    sender_gapless = 1'b1;
    // oversized width acts as the full line store width, oversized pool as the maximum
    set_geometry(9'd511, 9'd2, 9'd15, 9'd1);
    send_until_image_end();
    sender_gapless = 1'b0;
    // tall pools cut short at the bottom
    set_geometry(9'd1, 9'd20, 9'd8, 9'd8);
    send_until_image_end();
    receiver_calm = 1'b1;
    set_geometry(9'd1, 9'd300, 9'd1, 9'd12);
    send_until_image_end();
    receiver_calm = 1'b0;
  endtask

  task automatic test_mid_image_changes();
    set_geometry(9'd12, 9'd8, 9'd3, 9'd3);
    repeat (24) send_pixel(random_pixel());
    // third row of the window row becomes its last
    wait_idle();
    write_reg(REG_POOL_HEIGHT, 9'd2);
    repeat (12) send_pixel(random_pixel());
    // width shrinks below the current column
    repeat (5) send_pixel(random_pixel());
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 9'd2);
    repeat (3) send_pixel(random_pixel());
    // height shrinks below the current row
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 9'd3);
    send_until_image_end();
  endtask

  task automatic test_backpressure();
    set_geometry(9'd8, 9'd6, 9'd1, 9'd1);
    hold_off_cycles = 150;
    sender_gapless  = 1'b1;
    repeat (30) send_pixel(random_pixel());
    sender_gapless = 1'b0;
    wait_idle();
    send_until_image_end();
  endtask

  task automatic test_random_images();
    int unsigned            start_count;
    logic [CFG_DATA_W-1:0]  w;
    logic [CFG_DATA_W-1:0]  h;
    logic [CFG_DATA_W-1:0]  ph;
    logic [CFG_DATA_W-1:0]  pw;
    start_count = pixels_sent;
    while (pixels_sent - start_count < 200) begin
      w  = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 24)
                                                   : $urandom_range(1, 16));
      h  = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(1, 8));
      ph = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8));
      pw = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8));
      // junk above the pool field must be ignored
      if ($urandom_range(0, 3) == 0) begin
        ph[CFG_DATA_W-1:CFG_POOL_W] = (CFG_DATA_W-CFG_POOL_W)'($urandom());
        pw[CFG_DATA_W-1:CFG_POOL_W] = (CFG_DATA_W-CFG_POOL_W)'($urandom());
      end
      set_geometry(w, h, ph, pw);
      sender_gapless = ($urandom_range(0, 3) == 0);
      receiver_calm  = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) send_until_image_end();
    end
    sender_gapless = 1'b0;
    receiver_calm  = 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_IMAGE_WIDTH;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_pixel_value <= '0;
    reg_image_width  = RST_IMAGE_WIDTH;
    reg_image_height = RST_IMAGE_HEIGHT;
    reg_pool_height  = RST_POOL_HEIGHT;
    reg_pool_width   = RST_POOL_WIDTH;
    col_pos = 0;
    row_pos = 0;
    win_col = 0;
    win_row = 0;
    run_max = PIX_MIN;
    errors          = 0;
    pixels_sent     = 0;
    hold_off_cycles = 0;
    stall_left      = 0;
    sender_gapless  = 1'b0;
    receiver_calm   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_corner_pixels();
    test_register_extremes();
    test_mid_image_changes();
    test_backpressure();
    test_random_images();

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_windows.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_windows.size() != 0) begin
      $display("%0t: %0d pooled words expected but never received", $time,
               pending_windows.size());
      errors += pending_windows.size();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
